### sv/fcd_pkg.sv
package fcd_pkg;

  localparam int unsigned MaxPayloadDef = 31;
  localparam int unsigned WordBytesDef  = 8;
  localparam int unsigned LenCap        = 32;
  localparam int unsigned TextLenMax    = 63;

  localparam logic [7:0]  HeaderFirstRst  = 8'd67;
  localparam logic [7:0]  HeaderSecondRst = 8'd77;
  localparam logic [7:0]  TailFirstRst    = 8'd10;
  localparam logic [7:0]  TailSecondRst   = 8'd10;
  localparam logic [63:0] OnWordRst       = 64'd121424618734924;
  localparam logic [3:0]  OnLengthRst     = 4'd6;
  localparam logic [63:0] OffWordRst      = 64'd28823076150199628;
  localparam logic [3:0]  OffLengthRst    = 4'd7;

  typedef enum logic [2:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_TAIL_FIRST    = 3'd2,
    CFG_TAIL_SECOND   = 3'd3,
    CFG_ON_WORD       = 3'd4,
    CFG_ON_LENGTH     = 3'd5,
    CFG_OFF_WORD      = 3'd6,
    CFG_OFF_LENGTH    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LED_ON   = 2'd0,
    ST_LED_OFF  = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_TOO_LONG = 2'd3
  } frame_status_e;

  typedef enum logic [1:0] {
    PS_HUNT  = 2'b01,
    PS_FRAME = 2'b10
  } parse_state_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  tail_first;
    logic [7:0]  tail_second;
    logic [63:0] on_word;
    logic [3:0]  on_length;
    logic [63:0] off_word;
    logic [3:0]  off_length;
  } cfg_t;

  typedef struct packed {
    frame_status_e frame_status;
    logic [5:0]    payload_length;
    logic          led_level;
  } result_t;

endpackage

### sv/fcd_cfg.sv
module fcd_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  output fcd_pkg::cfg_t cfg_o
);
  import fcd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HEADER_FIRST:  cfg_d.header_first  = cfg_data_i[7:0];
        CFG_HEADER_SECOND: cfg_d.header_second = cfg_data_i[7:0];
        CFG_TAIL_FIRST:    cfg_d.tail_first    = cfg_data_i[7:0];
        CFG_TAIL_SECOND:   cfg_d.tail_second   = cfg_data_i[7:0];
        CFG_ON_WORD:       cfg_d.on_word       = cfg_data_i;
        CFG_ON_LENGTH:     cfg_d.on_length     = cfg_data_i[3:0];
        CFG_OFF_WORD:      cfg_d.off_word      = cfg_data_i;
        CFG_OFF_LENGTH:    cfg_d.off_length    = cfg_data_i[3:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstRst;
      cfg_q.header_second <= HeaderSecondRst;
      cfg_q.tail_first    <= TailFirstRst;
      cfg_q.tail_second   <= TailSecondRst;
      cfg_q.on_word       <= OnWordRst;
      cfg_q.on_length     <= OnLengthRst;
      cfg_q.off_word      <= OffWordRst;
      cfg_q.off_length    <= OffLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/fcd_parse.sv
module fcd_parse #(
  parameter int unsigned MAX_PAYLOAD = fcd_pkg::MaxPayloadDef,
  parameter int unsigned WORD_BYTES  = fcd_pkg::WordBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcd_pkg::cfg_t    cfg_i,
  input  logic             go_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output fcd_pkg::result_t res_o
);
  import fcd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned LenW = (CntW > 6) ? CntW : 6;
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_PAYLOAD + 1);

  parse_state_e    state_q, state_d;
  logic [7:0]      held_q, held_d;
  logic            held_vld_q, held_vld_d;
  logic [CntW-1:0] count_q, count_d;
  logic [5:0]      text_len_q, text_len_d;
  logic            text_end_q, text_end_d;
  logic            on_ok_q, on_ok_d;
  logic            off_ok_q, off_ok_d;
  logic            led_q, led_d;

  logic [3:0]      on_eff, off_eff;
  logic [7:0]      on_char, off_char;
  logic            on_fits, off_fits;
  logic            hdr_hit, tail_hit;
  logic [LenW-1:0] cnt_ext;
  result_t         res;
  logic            res_vld;

  always_comb begin
    on_eff   = (cfg_i.on_length > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : cfg_i.on_length;
    off_eff  = (cfg_i.off_length > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : cfg_i.off_length;
    on_char  = cfg_i.on_word[8*text_len_q[2:0] +: 8];
    off_char = cfg_i.off_word[8*text_len_q[2:0] +: 8];
    on_fits  = (text_len_q < 6'(on_eff)) && (on_char == held_q);
    off_fits = (text_len_q < 6'(off_eff)) && (off_char == held_q);
    hdr_hit  = held_vld_q && (held_q == cfg_i.header_first) && (byte_i == cfg_i.header_second);
    tail_hit = held_vld_q && (held_q == cfg_i.tail_first) && (byte_i == cfg_i.tail_second);
    cnt_ext  = LenW'(count_q);
  end

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    count_d    = count_q;
    text_len_d = text_len_q;
    text_end_d = text_end_q;
    on_ok_d    = on_ok_q;
    off_ok_d   = off_ok_q;
    led_d      = led_q;
    res_vld    = 1'b0;
    res.frame_status   = ST_UNKNOWN;
    res.payload_length = (cnt_ext > LenW'(LenCap)) ? 6'(LenCap) : 6'(cnt_ext);
    res.led_level      = led_q;

    if (count_q > CntW'(MAX_PAYLOAD)) begin
      res.frame_status = ST_TOO_LONG;
    end else if (on_ok_q && (text_len_q == 6'(on_eff))) begin
      res.frame_status = ST_LED_ON;
      res.led_level    = 1'b1;
    end else if (off_ok_q && (text_len_q == 6'(off_eff))) begin
      res.frame_status = ST_LED_OFF;
      res.led_level    = 1'b0;
    end

    if (go_i) begin
      unique case (state_q)
        PS_HUNT: begin
          if (hdr_hit) begin
            state_d    = PS_FRAME;
            held_vld_d = 1'b0;
            count_d    = '0;
            text_len_d = '0;
            text_end_d = 1'b0;
            on_ok_d    = 1'b1;
            off_ok_d   = 1'b1;
          end else begin
            held_d     = byte_i;
            held_vld_d = 1'b1;
          end
        end
        PS_FRAME: begin
          if (!tail_hit) begin
            if (held_vld_q) begin
              if (count_q < CntSat) begin
                count_d = count_q + 1'b1;
              end
              if (!text_end_q) begin
                if (held_q == 8'd0) begin
                  text_end_d = 1'b1;
                end else begin
                  if (!on_fits) begin
                    on_ok_d = 1'b0;
                  end
                  if (!off_fits) begin
                    off_ok_d = 1'b0;
                  end
                  if (text_len_q < 6'(TextLenMax)) begin
                    text_len_d = text_len_q + 1'b1;
                  end
                end
              end
            end
            held_d     = byte_i;
            held_vld_d = 1'b1;
          end else begin
            res_vld    = 1'b1;
            led_d      = res.led_level;
            state_d    = PS_HUNT;
            held_d     = '0;
            held_vld_d = 1'b0;
            count_d    = '0;
            text_len_d = '0;
            text_end_d = 1'b0;
            on_ok_d    = 1'b1;
            off_ok_d   = 1'b1;
          end
        end
        default: state_d = PS_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= PS_HUNT;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      count_q    <= '0;
      text_len_q <= '0;
      text_end_q <= 1'b0;
      on_ok_q    <= 1'b1;
      off_ok_q   <= 1'b1;
      led_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      count_q    <= count_d;
      text_len_q <= text_len_d;
      text_end_q <= text_end_d;
      on_ok_q    <= on_ok_d;
      off_ok_q   <= off_ok_d;
      led_q      <= led_d;
    end
  end

  assign res_valid_o = res_vld;
  assign res_o       = res;

endmodule

### sv/framed_command_deframer.sv
// A beat passes through the input register and then the result register, which shows its frame result, if any.
// Throughput: one received byte per cycle while no waiting result stalls it; the parser state updates in a single pass
// between the input register and the result register.
// A waiting result stalls the input register only while the result is not taken.
// Reset is asynchronous and active low: hunting for a header, LED off, configuration registers at defaults.
module framed_command_deframer #(
  parameter int unsigned MAX_PAYLOAD = fcd_pkg::MaxPayloadDef,
  parameter int unsigned WORD_BYTES  = fcd_pkg::WordBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [5:0]  payload_length_o,
  output logic        led_level_o
);
  import fcd_pkg::*;

  cfg_t       cfg;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       out_vld_q, out_vld_d;
  result_t    out_q, out_d;
  logic       go;
  logic       res_vld;
  result_t    res;

  assign cfg_ready_o = 1'b1;

  fcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fcd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .WORD_BYTES  (WORD_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .go_i        (go),
    .byte_i      (in_byte_q),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  assign go         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || go;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d  = 1'b1;
      in_byte_d = rx_byte_i;
    end else if (go) begin
      in_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (go && res_vld) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign out_valid_o      = out_vld_q;
  assign frame_status_o   = out_q.frame_status;
  assign payload_length_o = out_q.payload_length;
  assign led_level_o      = out_q.led_level;

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !go |=> in_vld_q && $stable(in_byte_q))
    else $error("Input beat lost while stalled.");

  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res_vld |=> out_vld_q)
    else $error("Frame result not registered.");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> payload_length_o <= 6'(LenCap))
    else $error("Payload length above cap.");

  a_led_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.frame_status == ST_LED_ON) |-> led_level_o)
    else $error("LED on status with LED dark.");

  a_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.frame_status == ST_LED_OFF) |-> !led_level_o)
    else $error("LED off status with LED lit.");
`endif

endmodule

### tb/fcd_checker.sv
module fcd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  frame_status_i,
  input  logic [5:0]  payload_length_i,
  input  logic        led_level_i,
  output int          mismatch_count_o = 0,
  output int          frames_pending_o = 0
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcd_pkg::*;

  cfg_t         cur_regs;
  parse_state_e parse_state;
  logic [7:0]   held;
  logic         held_ok;
  logic [5:0]   body_count;
  logic [5:0]   text_count;
  logic         text_done;
  logic         on_alive;
  logic         off_alive;
  logic         led_lit;
  result_t      frames_due [$];
  int           mismatches = 0;

  function automatic logic [3:0] cmd_chars(input logic [3:0] len);
    return (len > WordBytesDef) ? 4'(WordBytesDef) : len;
  endfunction

  function automatic logic char_matches(input logic [63:0] word, input logic [3:0] len,
                                        input logic [5:0] pos, input logic [7:0] b);
    if (pos >= cmd_chars(len)) return 1'b0;
    return word[8*pos +: 8] == b;
  endfunction

  task automatic clear_payload();
    body_count = '0;
    text_count = '0;
    text_done  = 1'b0;
    on_alive   = 1'b1;
    off_alive  = 1'b1;
  endtask

  task automatic take_text_byte(input logic [7:0] b);
    if (body_count < MaxPayloadDef + 1) body_count++;
    if (!text_done) begin
      if (b == 8'h00) begin
        text_done = 1'b1;
      end else begin
        if (!char_matches(cur_regs.on_word, cur_regs.on_length, text_count, b)) on_alive = 1'b0;
        if (!char_matches(cur_regs.off_word, cur_regs.off_length, text_count, b)) begin
          off_alive = 1'b0;
        end
        if (text_count < TextLenMax) text_count++;
      end
    end
  endtask

  task automatic close_frame();
    result_t r;
    if (body_count > MaxPayloadDef) begin
      r.frame_status = ST_TOO_LONG;
    end else if (on_alive && text_count == cmd_chars(cur_regs.on_length)) begin
      r.frame_status = ST_LED_ON;
      led_lit = 1'b1;
    end else if (off_alive && text_count == cmd_chars(cur_regs.off_length)) begin
      r.frame_status = ST_LED_OFF;
      led_lit = 1'b0;
    end else begin
      r.frame_status = ST_UNKNOWN;
    end
    r.payload_length = (body_count > LenCap) ? 6'(LenCap) : body_count;
    r.led_level      = led_lit;
    frames_due.push_back(r);
    parse_state = PS_HUNT;
    held_ok     = 1'b0;
    held        = '0;
    clear_payload();
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    if (parse_state == PS_HUNT) begin
      if (held_ok && held == cur_regs.header_first && b == cur_regs.header_second) begin
        parse_state = PS_FRAME;
        held_ok     = 1'b0;
        clear_payload();
      end else begin
        held    = b;
        held_ok = 1'b1;
      end
    end else if (held_ok && held == cur_regs.tail_first && b == cur_regs.tail_second) begin
      close_frame();
    end else begin
      if (held_ok) take_text_byte(held);
      held    = b;
      held_ok = 1'b1;
    end
  endtask

  task automatic check_result();
    result_t want;
    result_t got;
    got.frame_status   = frame_status_e'(frame_status_i);
    got.payload_length = payload_length_i;
    got.led_level      = led_level_i;
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result beat with nothing expected: status %0d length %0d led %0b",
                 $time, got.frame_status, got.payload_length, got.led_level);
      end
    end else begin
      want = frames_due.pop_front();
      if (want.frame_status != got.frame_status || want.payload_length != got.payload_length
          || want.led_level != got.led_level) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected status %0d length %0d led %0b, got status %0d length %0d led %0b",
                   $time, want.frame_status, want.payload_length, want.led_level,
                   got.frame_status, got.payload_length, got.led_level);
        end
      end
    end
  endtask

  // A result beat can never stem from an input beat of the same edge, so it is checked first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_regs = '{header_first: HeaderFirstRst, header_second: HeaderSecondRst,
                   tail_first: TailFirstRst, tail_second: TailSecondRst,
                   on_word: OnWordRst, on_length: OnLengthRst,
                   off_word: OffWordRst, off_length: OffLengthRst};
      parse_state = PS_HUNT;
      held        = '0;
      held_ok     = 1'b0;
      led_lit     = 1'b0;
      clear_payload();
      frames_due.delete();
      frames_pending_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_HEADER_FIRST:  cur_regs.header_first  = cfg_data_i[7:0];
          CFG_HEADER_SECOND: cur_regs.header_second = cfg_data_i[7:0];
          CFG_TAIL_FIRST:    cur_regs.tail_first    = cfg_data_i[7:0];
          CFG_TAIL_SECOND:   cur_regs.tail_second   = cfg_data_i[7:0];
          CFG_ON_WORD:       cur_regs.on_word       = cfg_data_i;
          CFG_ON_LENGTH:     cur_regs.on_length     = cfg_data_i[3:0];
          CFG_OFF_WORD:      cur_regs.off_word      = cfg_data_i;
          CFG_OFF_LENGTH:    cur_regs.off_length    = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) parse_rx_byte(rx_byte_i);
      frames_pending_o <= frames_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

### tb/tb_framed_command_deframer.sv
module tb_framed_command_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import fcd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 8;

  typedef enum int {
    FK_ON,
    FK_OFF,
    FK_NEAR,
    FK_EMPTY,
    FK_RANDOM,
    FK_LONG,
    FK_HEADER_INSIDE
  } frame_kind_e;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [63:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte      = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [1:0]  frame_status;
  logic [5:0]  payload_length;
  logic        led_level;

  int          mismatch_count;
  int          frames_pending;
  int          cycle_count  = 0;
  int          bytes_sent   = 0;
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;
  cfg_t        cur_cfg      = '{header_first: HeaderFirstRst, header_second: HeaderSecondRst,
                                tail_first: TailFirstRst, tail_second: TailSecondRst,
                                on_word: OnWordRst, on_length: OnLengthRst,
                                off_word: OffWordRst, off_length: OffLengthRst};

  always #5ns clk = ~clk;

  framed_command_deframer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .frame_status_o   (frame_status),
    .payload_length_o (payload_length),
    .led_level_o      (led_level)
  );

  fcd_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .frame_status_i   (frame_status),
    .payload_length_i (payload_length),
    .led_level_i      (led_level),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    cur_cfg = c;
    write_reg(CFG_HEADER_FIRST, 64'(c.header_first));
    write_reg(CFG_HEADER_SECOND, 64'(c.header_second));
    write_reg(CFG_TAIL_FIRST, 64'(c.tail_first));
    write_reg(CFG_TAIL_SECOND, 64'(c.tail_second));
    write_reg(CFG_ON_WORD, c.on_word);
    write_reg(CFG_ON_LENGTH, 64'(c.on_length));
    write_reg(CFG_OFF_WORD, c.off_word);
    write_reg(CFG_OFF_LENGTH, 64'(c.off_length));
    cfg_valid <= 1'b0;
  endtask

  // Every byte already in the block has to come out before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  body [$];
    logic [63:0] word;
    logic [3:0]  len;
    int          chars;
    int          idx;
    case (kind)
      FK_ON, FK_OFF, FK_NEAR: begin
        word  = (kind == FK_OFF) ? cur_cfg.off_word : cur_cfg.on_word;
        len   = (kind == FK_OFF) ? cur_cfg.off_length : cur_cfg.on_length;
        chars = (len > WordBytesDef) ? WordBytesDef : len;
        for (int i = 0; i < chars; i++) body.push_back(word[8*i +: 8]);
        if (kind == FK_NEAR) begin
          case ($urandom_range(0, 2))
            0: body.push_back(8'($urandom_range(1, 255)));
            1: if (body.size() > 0) void'(body.pop_back());
            default: begin
              if (body.size() > 0) begin
                idx = $urandom_range(0, body.size() - 1);
                body[idx] ^= 8'($urandom_range(1, 255));
              end
            end
          endcase
        end
        if ($urandom_range(0, 3) == 0) begin
          body.push_back(8'h00);
          repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
        end
      end
      FK_RANDOM: begin
        repeat ($urandom_range(0, 36)) begin
          body.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        end
      end
      FK_LONG: begin
        repeat ($urandom_range(32, 45)) body.push_back(8'($urandom));
      end
      FK_HEADER_INSIDE: begin
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        body.push_back(cur_cfg.header_first);
        body.push_back(cur_cfg.header_second);
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
      end
      default: ;
    endcase
    push_byte(cur_cfg.header_first);
    push_byte(cur_cfg.header_second);
    foreach (body[i]) push_byte(body[i]);
    push_byte(cur_cfg.tail_first);
    push_byte(cur_cfg.tail_second);
  endtask

  task automatic run_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else if (pick < 12) begin
        push_byte(cur_cfg.header_first);
        push_byte(cur_cfg.header_second);
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else if (pick < 34) begin
        send_frame(FK_ON);
      end else if (pick < 56) begin
        send_frame(FK_OFF);
      end else if (pick < 70) begin
        send_frame(FK_NEAR);
      end else if (pick < 76) begin
        send_frame(FK_EMPTY);
      end else if (pick < 88) begin
        send_frame(FK_RANDOM);
      end else if (pick < 94) begin
        send_frame(FK_LONG);
      end else begin
        send_frame(FK_HEADER_INSIDE);
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(FK_ON);
    send_frame(FK_OFF);
    send_frame(FK_EMPTY);

    hold_request = 1'b1;
    run_traffic(150);
    settle();

    load_config('{header_first: 8'h00, header_second: 8'hFF, tail_first: 8'hFF,
                  tail_second: 8'h00, on_word: {$urandom, $urandom}, on_length: 4'd8,
                  off_word: {$urandom, $urandom}, off_length: 4'd15});
    run_traffic(170);
    settle();

    steady = 1'b1;
    load_config('{header_first: 8'hFF, header_second: 8'hFF, tail_first: 8'h0A,
                  tail_second: 8'h0D, on_word: {$urandom, $urandom}, on_length: 4'd0,
                  off_word: '1, off_length: 4'd3});
    run_traffic(170);
    settle();
    steady = 1'b0;

    load_config('{header_first: 8'h55, header_second: 8'hAA, tail_first: 8'h00,
                  tail_second: 8'h00, on_word: 64'h0000_0000_3300_6F31, on_length: 4'd4,
                  off_word: '0, off_length: 4'd0});
    run_traffic(170);
    settle();

    load_config('{header_first: HeaderFirstRst, header_second: HeaderSecondRst,
                  tail_first: HeaderFirstRst, tail_second: HeaderSecondRst,
                  on_word: {$urandom, $urandom}, on_length: 4'd1,
                  off_word: {$urandom, $urandom}, off_length: 4'd2});
    run_traffic(170);
    settle();

    load_config('{header_first: 8'($urandom), header_second: 8'($urandom),
                  tail_first: 8'($urandom), tail_second: 8'($urandom),
                  on_word: {$urandom, $urandom}, on_length: 4'($urandom_range(0, 15)),
                  off_word: {$urandom, $urandom}, off_length: 4'($urandom_range(0, 15))});
    run_traffic(170);
    settle();

    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
